[sv/drive_command_packet_receiver_macros.svh]
// Assertion helpers for the drive command packet receiver.
// They expect clk and rst_n in the scope where they are used.
`ifndef DRIVE_COMMAND_PACKET_RECEIVER_MACROS_SVH
`define DRIVE_COMMAND_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication
`define DCPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DCPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dcpr_pkg.sv]
package dcpr_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES   = 7;
    localparam int unsigned PAYLOAD_COUNT = FRAME_BYTES - 2;
    localparam int unsigned POS_W         = $clog2(FRAME_BYTES);
    localparam int unsigned PIDX_W        = $clog2(PAYLOAD_COUNT);
    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] START_BYTE = 8'd253;
    localparam logic signed [11:0] EFFORT_OFFSET = 12'sd1000;

    // Item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLL_PERIOD   = 2'd0;
    localparam logic [1:0] CFG_DRIVE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_FAN_TIMEOUT   = 2'd2;
    localparam logic [1:0] CFG_FAN_VERB      = 2'd3;

    // Configuration reset values
    localparam logic [9:0]  POLL_PERIOD_RST = 10'd10;
    localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
    localparam logic [7:0]  FAN_VERB_RST    = 8'd0;

    // Control from the frame logic to one watchdog
    typedef struct packed {
        logic tick;   // a poll tick is processed this cycle
        logic seen;   // a command arrived since the previous tick
        logic arm;    // a command restarts the watch this cycle
    } watch_ctrl_t;

    // Expected check byte: 255 - (sum mod 255); sum is at most 5*255
    function automatic logic [7:0] check_expect(input logic [10:0] sum);
        logic [8:0] folded;
        folded = {1'b0, sum[7:0]} + {6'b0, sum[10:8]};
        if (folded >= 9'd255)
        begin
            folded = folded - 9'd255;
        end
        return 8'(9'd255 - folded);
    endfunction

    // Motor effort from a payload byte: byte*8 - 1000
    function automatic logic signed [11:0] effort_of(input logic [7:0] b);
        return $signed({1'b0, b, 3'b000}) - EFFORT_OFFSET;
    endfunction

endpackage

[sv/dcpr_watch.sv]
module dcpr_watch
    import dcpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  watch_ctrl_t ctrl,
    input  logic [9:0]  period,
    input  logic [15:0] limit,
    output logic        fire
);

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        active_reg;
    logic        active_next;
    logic [15:0] count_inc;
    logic [25:0] elapsed;
    logic        counting;

    // Saturating tick count and elapsed time
    assign count_inc = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
    assign elapsed   = 26'(count_inc) * 26'(period);
    assign counting  = ctrl.tick && !ctrl.seen && active_reg;
    assign fire      = counting && (elapsed > 26'(limit));

    // Arm on a command, count on ticks, disarm on firing
    always_comb
    begin
        count_next  = count_reg;
        active_next = active_reg;
        if (ctrl.arm)
        begin
            count_next  = 16'd0;
            active_next = 1'b1;
        end
        else if (counting)
        begin
            count_next = count_inc;
            if (fire)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 16'd0;
            active_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

endmodule

[sv/drive_command_packet_receiver.sv]
// Drive command packet receiver: frame parser, motor efforts, fan mode, watchdogs.
// An accepted item reaches its result through the input register and then the result register.
// Throughput: one item per cycle; a full pipeline stalls only while the result is held.
// Reset (rst_n, asynchronous, active low) empties both stages, returns to hunting,
// zeroes efforts, fan mode and watchdogs, and loads the configuration defaults.
`include "drive_command_packet_receiver_macros.svh"

module drive_command_packet_receiver
    import dcpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [7:0]         rx_byte,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_ok,
    output logic               frame_bad,
    output logic signed [11:0] effort_left,
    output logic signed [11:0] effort_right,
    output logic signed [11:0] effort_flipper,
    output logic [7:0]         verb,
    output logic [7:0]         argument,
    output logic               fan_manual,
    output logic [7:0]         fan_speed,
    output logic               drive_timed_out,
    output logic               fan_timed_out
);

    // Configuration registers
    logic [9:0]  poll_period_reg;
    logic [15:0] drive_timeout_reg;
    logic [15:0] fan_timeout_reg;
    logic [7:0]  fan_verb_reg;

    // Input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_func_reg;
    logic [7:0]  s1_byte_reg;

    // Frame and command state
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [10:0]        sum_reg;
    logic [10:0]        sum_next;
    logic [7:0]         payload_reg [PAYLOAD_COUNT];
    logic               payload_we;
    logic [PIDX_W-1:0]  payload_idx;
    logic signed [11:0] effort_reg [3];
    logic signed [11:0] effort_next [3];
    logic [7:0]         fan_level_reg;
    logic [7:0]         fan_level_next;
    logic               fan_on_reg;
    logic               fan_on_next;
    logic               drive_seen_reg;
    logic               drive_seen_next;
    logic               fan_seen_reg;
    logic               fan_seen_next;

    // Result register
    logic               res_valid_reg;
    logic               res_valid_next;
    logic               res_ok_reg;
    logic               res_bad_reg;
    logic [7:0]         res_verb_reg;
    logic [7:0]         res_arg_reg;
    logic               res_dto_reg;
    logic               res_fto_reg;

    // Step signals
    logic               advance;
    logic               step;
    logic               is_tick;
    logic               good;
    logic               bad;
    logic               fan_cmd;
    logic               drive_fire;
    logic               fan_fire;
    logic [7:0]         verb_val;
    logic [7:0]         arg_val;
    watch_ctrl_t        drive_ctrl;
    watch_ctrl_t        fan_ctrl;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_period_reg   <= POLL_PERIOD_RST;
            drive_timeout_reg <= TIMEOUT_RST;
            fan_timeout_reg   <= TIMEOUT_RST;
            fan_verb_reg      <= FAN_VERB_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_POLL_PERIOD:   poll_period_reg   <= cfg_data[9:0];
                CFG_DRIVE_TIMEOUT: drive_timeout_reg <= cfg_data;
                CFG_FAN_TIMEOUT:   fan_timeout_reg   <= cfg_data;
                CFG_FAN_VERB:      fan_verb_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: both stages move together unless the result is held
    assign advance        = !(res_valid_reg && out_stall);
    assign in_stall       = s1_valid_reg && !advance;
    assign step           = s1_valid_reg && advance;
    assign s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
    assign res_valid_next = advance ? s1_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_func_reg <= func;
            s1_byte_reg <= rx_byte;
        end
    end

    // Frame completion decode
    assign is_tick  = (s1_func_reg == FUNC_TICK);
    assign good     = step && !is_tick && (pos_reg == POS_CHECK)
                      && (check_expect(sum_reg) == s1_byte_reg);
    assign bad      = step && !is_tick && (pos_reg == POS_CHECK)
                      && (check_expect(sum_reg) != s1_byte_reg);
    assign fan_cmd  = good && (payload_reg[3] == fan_verb_reg);
    assign verb_val = good ? payload_reg[3] : 8'd0;
    assign arg_val  = good ? payload_reg[4] : 8'd0;

    // Watchdog control
    assign drive_ctrl = '{tick: step && is_tick, seen: drive_seen_reg, arm: good};
    assign fan_ctrl   = '{tick: step && is_tick, seen: fan_seen_reg, arm: fan_cmd};

    dcpr_watch u_drive_watch
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (drive_ctrl),
        .period (poll_period_reg),
        .limit  (drive_timeout_reg),
        .fire   (drive_fire)
    );

    dcpr_watch u_fan_watch
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (fan_ctrl),
        .period (poll_period_reg),
        .limit  (fan_timeout_reg),
        .fire   (fan_fire)
    );

    // Frame position and running sum
    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        payload_we  = 1'b0;
        payload_idx = PIDX_W'(pos_reg - POS_W'(1));
        if (step && !is_tick)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (s1_byte_reg == START_BYTE)
                begin
                    pos_next = POS_W'(1);
                    sum_next = 11'd0;
                end
            end
            else if (pos_reg < POS_CHECK)
            begin
                payload_we = 1'b1;
                sum_next   = sum_reg + {3'b000, s1_byte_reg};
                pos_next   = pos_reg + POS_W'(1);
            end
            else
            begin
                pos_next = POS_HUNT;
            end
        end
    end

    // Efforts, fan mode and seen flags
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            effort_next[i] = effort_reg[i];
        end
        fan_level_next  = fan_level_reg;
        fan_on_next     = fan_on_reg;
        drive_seen_next = drive_seen_reg;
        fan_seen_next   = fan_seen_reg;
        if (step && is_tick)
        begin
            if (fan_fire)
            begin
                fan_on_next = 1'b0;
            end
            if (drive_fire)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    effort_next[i] = 12'sd0;
                end
            end
            drive_seen_next = 1'b0;
            fan_seen_next   = 1'b0;
        end
        else if (good)
        begin
            for (int i = 0; i < 3; i++)
            begin
                effort_next[i] = effort_of(payload_reg[i]);
            end
            drive_seen_next = 1'b1;
            if (fan_cmd)
            begin
                fan_level_next = payload_reg[4];
                fan_on_next    = 1'b1;
                fan_seen_next  = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_HUNT;
            sum_reg        <= 11'd0;
            for (int i = 0; i < 3; i++)
            begin
                effort_reg[i] <= 12'sd0;
            end
            fan_level_reg  <= 8'd0;
            fan_on_reg     <= 1'b0;
            drive_seen_reg <= 1'b0;
            fan_seen_reg   <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            for (int i = 0; i < 3; i++)
            begin
                effort_reg[i] <= effort_next[i];
            end
            fan_level_reg  <= fan_level_next;
            fan_on_reg     <= fan_on_next;
            drive_seen_reg <= drive_seen_next;
            fan_seen_reg   <= fan_seen_next;
        end
    end

    // Payload bytes of the frame in progress
    always_ff @(posedge clk)
    begin
        if (payload_we)
        begin
            payload_reg[payload_idx] <= s1_byte_reg;
        end
    end

    // Per-item result fields; efforts and fan fields mirror the state
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_ok_reg   <= good;
            res_bad_reg  <= bad;
            res_verb_reg <= verb_val;
            res_arg_reg  <= arg_val;
            res_dto_reg  <= is_tick && drive_fire;
            res_fto_reg  <= is_tick && fan_fire;
        end
    end

    // Output ports
    assign out_valid       = res_valid_reg;
    assign frame_ok        = res_ok_reg;
    assign frame_bad       = res_bad_reg;
    assign effort_left     = effort_reg[0];
    assign effort_right    = effort_reg[1];
    assign effort_flipper  = effort_reg[2];
    assign verb            = res_verb_reg;
    assign argument        = res_arg_reg;
    assign fan_manual      = fan_on_reg;
    assign fan_speed       = fan_level_reg;
    assign drive_timed_out = res_dto_reg;
    assign fan_timed_out   = res_fto_reg;

    // Checks
    `DCPR_ASSERT_NOW(a_stall_only_when_held, in_stall, out_valid && out_stall, "input stalled while output free")
    `DCPR_ASSERT_NEXT(a_frame_end_hunts, good || bad, pos_reg == POS_HUNT, "frame end did not return to hunting")
    `DCPR_ASSERT_NOW(a_no_cmd_without_frame, out_valid && !frame_ok, verb == 8'd0 && argument == 8'd0, "verb or argument without good frame")
    `DCPR_ASSERT_NOW(a_drive_timeout_zeroes, out_valid && drive_timed_out, effort_left == 12'sd0 && effort_right == 12'sd0 && effort_flipper == 12'sd0, "efforts not zero after drive timeout")
    `DCPR_ASSERT_NOW(a_fan_timeout_ends, out_valid && fan_timed_out, !fan_manual, "manual fan still on after fan timeout")

endmodule
